### sv/dynamic_palette_indexer_unit_defines.svh
// Assertion macros shared by the palette indexer RTL.
`ifndef DYNAMIC_PALETTE_INDEXER_UNIT_DEFINES_SVH
`define DYNAMIC_PALETTE_INDEXER_UNIT_DEFINES_SVH

// Implication checked on every edge outside reset.
`define DPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DPI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dpi_pkg.sv
// ----------------------------------------------------------------------------
// dpi_pkg
// Shared types and constants of the dynamic palette indexer.
// ----------------------------------------------------------------------------
package dpi_pkg;
  localparam int unsigned HashW   = 12;
  localparam int unsigned RgbW    = 24;
  localparam int unsigned DistW   = 18;

  typedef logic [RgbW-1:0]  rgb_t;
  typedef logic [HashW-1:0] hash_t;
  typedef logic [DistW-1:0] dist_t;

  // Input item payload
  typedef struct packed {
    logic [31:0] pixel;
  } dpi_in_t;

  // Result item payload
  typedef struct packed {
    logic [7:0] colour_slot;
    logic       slot_added;
    rgb_t       added_colour;
  } dpi_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;      // zero one cache slot entry of the clearing pass
    logic load;       // capture a new pixel, start hash read
    logic cmp_hit;    // evaluate cache hit from registered read
    logic scan_first; // start palette walk at slot 1
    logic scan_next;  // advance palette walk
    logic alloc;      // write new slot
    logic cache_wr;   // write cache entry with found slot
    logic finish;     // load result register
  } dpi_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;   // clearing pass is at its last entry
    logic black;
    logic hit;
    logic match;      // current scanned slot matches
    logic scan_last;  // current scanned slot is the last used one
    logic full;
    logic out_busy;   // result register occupied and not being taken
  } dpi_sts_t;

  function automatic hash_t hash_of(input rgb_t c);
    logic [RgbW-1:0] h;
    begin
      h = (c >> 12) ^ (c >> 4) ^ c;
      return h[HashW-1:0];
    end
  endfunction
endpackage

### sv/dpi_stream_if.sv
// ----------------------------------------------------------------------------
// dpi_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface dpi_stream_if #(parameter type payload_t = logic [31:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/dpi_ctrl.sv
// ----------------------------------------------------------------------------
// dpi_ctrl
// Sequencer for lookup: cache probe, palette walk, allocate or nearest search.
// ----------------------------------------------------------------------------
module dpi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpi_pkg::dpi_sts_t sts,
  output dpi_pkg::dpi_cmd_t cmd
);
  import dpi_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PROBE, S_SCAN, S_WAIT, S_DONE} state_t;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        // walk the cache slot table once after reset
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.cmp_hit = 1'b1;
        if (sts.black || sts.hit) begin
          state_nxt = S_DONE;
        end else if (sts.scan_last) begin
          // palette empty: straight to allocate
          cmd.alloc = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_first = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.cache_wr = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.scan_last) begin
          if (!sts.full) cmd.alloc = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### sv/dpi_datapath.sv
// ----------------------------------------------------------------------------
// dpi_datapath
// Palette and cache memories, scan walker, distance search, result register.
// ----------------------------------------------------------------------------
`include "dynamic_palette_indexer_unit_defines.svh"
module dpi_datapath #(
  parameter int unsigned PALETTE_SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       pixel,
  input  dpi_pkg::dpi_cmd_t cmd,
  output dpi_pkg::dpi_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_slot,
  output logic              out_added,
  output dpi_pkg::rgb_t     out_colour
);
  import dpi_pkg::*;

  localparam int unsigned CntW = $clog2(PALETTE_SLOTS + 1);
  localparam int unsigned IdxW = $clog2(PALETTE_SLOTS);
  localparam int unsigned Entries = 1 << HashW;

  // Memories
  rgb_t           pal_mem [PALETTE_SLOTS];
  rgb_t           cc_mem  [Entries];
  logic [7:0]     cs_mem  [Entries];

  rgb_t           rgb_r, pal_q_r, cc_q_r;
  hash_t          h_r;
  hash_t          clr_r;
  logic [7:0]     cs_q_r;
  logic [CntW-1:0] used_r;
  logic [IdxW-1:0] scan_r;
  logic           scan_vld_r;
  logic [IdxW-1:0] best_r;
  logic [DistW:0] bd_r;
  logic [7:0]     slot_r;
  logic           added_r;
  logic           ovld_r;
  logic [7:0]     oslot_r;
  logic           oadd_r;
  rgb_t           ocol_r;

  logic full;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] last_idx;
  logic [8:0] dr, dg, db;
  dist_t sq_sum;
  logic [7:0] cur_slot;

  assign full     = (used_r == CntW'(PALETTE_SLOTS));
  assign last_idx = IdxW'(used_r - CntW'(1));
  assign cur_slot = 8'(scan_r);

  // palette read address: walker position
  always_comb begin
    if (cmd.scan_first) rd_addr = IdxW'(1);
    else if (cmd.scan_next) rd_addr = scan_r + IdxW'(1);
    else rd_addr = scan_r;
  end

  // Palette memory
  always_ff @(posedge clk) begin
    if (cmd.alloc) pal_mem[IdxW'(used_r)] <= rgb_r;
    pal_q_r <= pal_mem[rd_addr];
  end

  // Clearing pass position over the cache slot table
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear) clr_r <= clr_r + HashW'(1);
  end

  // Cache memories, read with hash of incoming pixel
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      cs_mem[clr_r] <= 8'd0;
    end else if (cmd.alloc || cmd.cache_wr) begin
      cc_mem[h_r] <= rgb_r;
      cs_mem[h_r] <= cmd.alloc ? 8'(used_r) : cur_slot;
    end
    cc_q_r <= cc_mem[hash_of(pixel[RgbW-1:0])];
    cs_q_r <= cs_mem[hash_of(pixel[RgbW-1:0])];
  end

  // Distance of scanned slot
  always_comb begin
    dr = {1'b0, pal_q_r[23:16]} - {1'b0, rgb_r[23:16]};
    dg = {1'b0, pal_q_r[15:8]}  - {1'b0, rgb_r[15:8]};
    db = {1'b0, pal_q_r[7:0]}   - {1'b0, rgb_r[7:0]};
    if (dr[8]) dr = -dr;
    if (dg[8]) dg = -dg;
    if (db[8]) db = -db;
    sq_sum = DistW'({8'd0, dr[7:0]} * {8'd0, dr[7:0]})
           + DistW'({8'd0, dg[7:0]} * {8'd0, dg[7:0]})
           + DistW'({8'd0, db[7:0]} * {8'd0, db[7:0]});
  end

  // Walker, search and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= CntW'(1);
      scan_vld_r <= 1'b0;
    end else begin
      if (cmd.alloc) used_r <= used_r + CntW'(1);
      if (cmd.load) scan_vld_r <= 1'b0;
      else if (cmd.scan_first) scan_vld_r <= 1'b1;
    end
    if (cmd.load) begin
      rgb_r <= pixel[RgbW-1:0];
      h_r   <= hash_of(pixel[RgbW-1:0]);
      bd_r  <= {1'b1, {DistW{1'b0}}};
      best_r <= IdxW'(1);
      scan_r <= '0;
    end else begin
      if (cmd.scan_first) scan_r <= IdxW'(1);
      else if (cmd.scan_next) scan_r <= scan_r + IdxW'(1);
      if (scan_vld_r && ({1'b0, sq_sum} < bd_r)) begin
        bd_r <= {1'b0, sq_sum};
        best_r <= scan_r;
      end
    end
    if (cmd.load) begin
      added_r <= 1'b0;
      slot_r <= '0;
    end else if (cmd.alloc) begin
      slot_r <= 8'(used_r);
      added_r <= 1'b1;
    end else if (cmd.cache_wr) begin
      slot_r <= cur_slot;
    end else if (cmd.cmp_hit) begin
      slot_r <= (rgb_r == '0) ? 8'd0 : cs_q_r;
    end
  end

  // nearest result is best including current compare
  logic [7:0] near_slot;
  assign near_slot = (({1'b0, sq_sum} < bd_r)) ? cur_slot : 8'(best_r);

  logic near_r;
  always_ff @(posedge clk) begin
    if (!rst_n) near_r <= 1'b0;
    else if (cmd.load) near_r <= 1'b0;
    else if (scan_vld_r && sts.scan_last && full) near_r <= 1'b1;
  end
  logic [7:0] near_q_r;
  always_ff @(posedge clk) begin
    if (scan_vld_r && sts.scan_last && full && !near_r) near_q_r <= near_slot;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (cmd.finish) ovld_r <= 1'b1;
    else if (out_ready) ovld_r <= 1'b0;
    if (cmd.finish) begin
      oslot_r <= near_r ? near_q_r : slot_r;
      oadd_r  <= added_r;
      ocol_r  <= added_r ? rgb_r : '0;
    end
  end

  assign sts.clr_last  = (clr_r == '1);
  assign sts.black     = (rgb_r == '0);
  assign sts.hit       = (cs_q_r != 8'd0) && (cc_q_r == rgb_r);
  assign sts.match     = scan_vld_r && (pal_q_r == rgb_r);
  assign sts.scan_last = scan_vld_r ? (scan_r == last_idx) : (used_r == CntW'(1));
  assign sts.full      = full;
  assign sts.out_busy  = ovld_r && !out_ready;

  assign out_valid  = ovld_r;
  assign out_slot   = oslot_r;
  assign out_added  = oadd_r;
  assign out_colour = ocol_r;

  `DPI_ASSERT_IMP(a_used_range, 1'b1, used_r != '0 && used_r <= CntW'(PALETTE_SLOTS), "bad count")
  `DPI_ASSERT_NXT(a_alloc_cnt, cmd.alloc, used_r == $past(used_r) + CntW'(1), "count not advanced")
  `DPI_ASSERT_IMP(a_no_alloc_full, cmd.alloc, !full, "allocation into full palette")
endmodule

### sv/dynamic_palette_indexer_unit.sv
// ----------------------------------------------------------------------------
// dynamic_palette_indexer_unit
// Adaptive palette indexer: maps RGB pixels to palette slots.
// ----------------------------------------------------------------------------
// Input channel in_ch: one 32-bit pixel per item, low 24 bits are RGB.
// Output channel out_ch: colour_slot, slot_added, added_colour per item.
// One item is processed at a time. Black or a cache hit goes from the probe
// straight to the result; a miss on an empty palette is added at once. Any
// other miss walks the palette one slot per cycle through its read port,
// from slot 1 to the last used slot: once the palette is full the walk is a
// nearest-colour search, else an unmatched colour is added in the next free
// slot. A palette match ends the walk early.
// After reset a clearing pass empties all 4096 cache slot table entries
// with in_ready low; the next free slot starts at 1.
// The result sits in an output register. While the receiver stalls it holds;
// the next item is accepted and processed, and its result waits, with
// in_ready low, until the register is taken.
// ----------------------------------------------------------------------------
module dynamic_palette_indexer_unit #(
  parameter int unsigned PALETTE_SLOTS = 256
) (
  input  logic clk,
  input  logic rst_n,
  dpi_stream_if.sink   in_ch,
  dpi_stream_if.source out_ch
);
  import dpi_pkg::*;

  dpi_cmd_t cmd;
  dpi_sts_t sts;

  dpi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  dpi_datapath #(.PALETTE_SLOTS(PALETTE_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .pixel(in_ch.data.pixel), .cmd(cmd), .sts(sts),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_slot(out_ch.data.colour_slot),
    .out_added(out_ch.data.slot_added),
    .out_colour(out_ch.data.added_colour)
  );
endmodule
